@@ sv/sem_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

    localparam int MaxSide   = 1024;
    localparam int SideWidth = 11;
    localparam int PosWidth  = 10;
    localparam int MagWidth  = 9;
    localparam logic [SideWidth-1:0] SideReset = 11'd512;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
    } t_pix_in;

    typedef struct packed {
        logic [PosWidth-1:0] out_row;
        logic [PosWidth-1:0] out_col;
        logic [MagWidth-1:0] mag_red;
        logic [MagWidth-1:0] mag_green;
        logic [MagWidth-1:0] mag_blue;
        logic                frame_last;
    } t_mag_out;

    // One gradient pair of a channel, already clamped.
    typedef struct packed {
        logic [7:0] gv;
        logic [7:0] gh;
    } t_grad;

    typedef struct packed {
        logic [PosWidth-1:0] row;
        logic [PosWidth-1:0] col;
        logic                last;
    } t_tag;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WAIT,
        ST_ROOT
    } t_state;

    function automatic logic [7:0] clamp_grad(input logic signed [11:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 12'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ sv/sem_line_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sem_line_mem #(
    parameter int MAX_SIDE = sem_pkg::MaxSide,
    parameter int AW       = $clog2(MAX_SIDE)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [47:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [47:0]   o_rdata
);

    // Both line stores share one word: upper half is the row above, lower
    // half the row two above.
    logic [47:0] mem [MAX_SIDE];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/sem_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sem_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [16:0] i_value,
    output logic             o_done,
    output logic [8:0]       o_root
);

    // Bit-pair restoring square root, two result bits per cycle.
    logic [16:0] r_rem, n_rem;
    logic [17:0] r_res, n_res;
    logic [17:0] r_bit, n_bit;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    always_comb begin
        logic [17:0] rem, res, bitv;
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        rem  = {1'b0, r_rem};
        res  = r_res;
        bitv = r_bit;
        if (i_start) begin
            n_rem  = i_value;
            n_res  = 18'd0;
            n_bit  = 18'h10000;
            n_busy = 1'b1;
        end else if (r_busy) begin
            for (int k = 0; k < 2; k++) begin
                if (bitv != 18'd0) begin
                    if (rem >= res + bitv) begin
                        rem = rem - (res + bitv);
                        res = (res >> 1) + bitv;
                    end else begin
                        res = res >> 1;
                    end
                    bitv = bitv >> 2;
                end
            end
            n_rem = rem[16:0];
            n_res = res;
            n_bit = bitv;
            if (bitv == 18'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[8:0];

endmodule
`default_nettype wire

@@ sv/sobel_edge_magnitude_rgb_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sobel edge magnitude on a square RGB image streamed in raster order.
// Input channel: i_pix_valid / o_pix_stall with payload i_pix. Output
// channel: o_mag_valid / i_mag_stall with payload o_mag. One transfer on
// the output follows each input pixel whose 3x3 window centre is interior.
// Configuration: i_cfg_we writes image_side from i_cfg_data; the user
// must write it only while idle, and the block does not enforce this.
// Each pixel passes through accept, line store read and window update,
// and gradients. A pixel with a result then starts the three square
// roots, done in parallel on the two-bits-per-cycle root units. No new
// pixel is taken until the last one is through these steps; the line
// store single read port and the root units set this. The result waits
// in an output register; the next pixel is taken and read from the line
// store while it waits, and its result is held back until the register
// frees.
// Reset clears the window, the position counters and image_side to 512.
// The line stores are not cleared; the first two rows fill them before
// any result reads them.
module sobel_edge_magnitude_rgb_core #(
    parameter int MAX_SIDE = sem_pkg::MaxSide
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sem_pkg::SideWidth-1:0]       i_cfg_data,
    input  wire logic                                i_pix_valid,
    output logic                                     o_pix_stall,
    input  wire sem_pkg::t_pix_in                    i_pix,
    output logic                                     o_mag_valid,
    input  wire logic                                i_mag_stall,
    output sem_pkg::t_mag_out                        o_mag
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam int CW = sem_pkg::SideWidth + 2;

    sem_pkg::t_state r_state, n_state;
    logic [sem_pkg::SideWidth-1:0] r_side;
    logic [CW-1:0] r_row, n_row, r_col, n_col;
    logic [CW-1:0] r_r, r_c;
    logic [23:0] r_pix;
    logic [23:0] r_win [9];
    logic [47:0] rd_data;
    logic        mem_we;
    logic [CW-1:0] side;
    logic          emit;
    sem_pkg::t_grad r_g [3];
    sem_pkg::t_tag  r_tag;
    logic          sq_start;
    logic [16:0]   sq_val [3];
    logic [2:0]    sq_done;
    logic [8:0]    sq_root [3];
    logic          r_ovalid;
    sem_pkg::t_mag_out r_out;

    always_comb begin
        if (r_side < 11'd3) begin
            side = CW'(3);
        end else if ({2'b00, r_side} > CW'(MAX_SIDE)) begin
            side = CW'(MAX_SIDE);
        end else begin
            side = {2'b00, r_side};
        end
    end

    assign mem_we = (r_state == sem_pkg::ST_READ) && (r_c < CW'(MAX_SIDE));
    assign emit = (r_r >= CW'(2)) && (r_c >= CW'(2)) && (r_r < side) && (r_c < side);

    sem_line_mem #(.MAX_SIDE(MAX_SIDE), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_c[AW-1:0]),
        .i_wdata ({r_pix, rd_data[47:24]}),
        .i_raddr (n_col[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Position: n_col is the address read for the pixel about to arrive.
    always_comb begin
        n_state = r_state;
        n_row = r_row;
        n_col = r_col;
        sq_start = 1'b0;
        o_pix_stall = 1'b1;
        unique case (r_state)
            sem_pkg::ST_IDLE: begin
                o_pix_stall = 1'b0;
                if (i_pix_valid) begin
                    if (i_pix.frame_start) begin
                        n_row = '0;
                        n_col = '0;
                    end
                    n_state = sem_pkg::ST_READ;
                end
            end
            sem_pkg::ST_READ: begin
                n_state = sem_pkg::ST_CALC;
                if (r_c + CW'(1) >= side) begin
                    n_col = '0;
                    n_row = (r_r + CW'(1) >= side) ? '0 : r_r + CW'(1);
                end else begin
                    n_col = r_c + CW'(1);
                end
            end
            sem_pkg::ST_CALC: begin
                if (emit) begin
                    n_state = sem_pkg::ST_WAIT;
                end else begin
                    n_state = sem_pkg::ST_IDLE;
                end
            end
            sem_pkg::ST_WAIT: begin
                if (!r_ovalid || !i_mag_stall) begin
                    n_state = sem_pkg::ST_ROOT;
                    sq_start = 1'b1;
                end
            end
            sem_pkg::ST_ROOT: begin
                if (sq_done[0]) begin
                    n_state = sem_pkg::ST_IDLE;
                end
            end
            default: n_state = sem_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sem_pkg::ST_IDLE;
            r_side  <= sem_pkg::SideReset;
            r_row   <= '0;
            r_col   <= '0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            if (i_cfg_we) begin
                r_side <= i_cfg_data;
            end
            if (r_state == sem_pkg::ST_READ) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= (r_c < CW'(MAX_SIDE)) ? rd_data[23:0] : 24'd0;
                r_win[5] <= (r_c < CW'(MAX_SIDE)) ? rd_data[47:24] : 24'd0;
                r_win[8] <= r_pix;
            end
            if (sq_done[0]) begin
                r_ovalid <= 1'b1;
            end else if (!i_mag_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sem_pkg::ST_IDLE && i_pix_valid) begin
            r_pix <= {i_pix.pix_red, i_pix.pix_green, i_pix.pix_blue};
            r_r   <= i_pix.frame_start ? '0 : r_row;
            r_c   <= i_pix.frame_start ? '0 : r_col;
        end
        if (r_state == sem_pkg::ST_CALC) begin
            for (int ch = 0; ch < 3; ch++) begin
                logic signed [11:0] gv, gh;
                logic [11:0] p [9];
                for (int k = 0; k < 9; k++) begin
                    p[k] = {4'd0, r_win[k][(2-ch)*8 +: 8]};
                end
                gv = p[0] + (p[1] << 1) + p[2] - p[6] - (p[7] << 1) - p[8];
                gh = p[0] + (p[3] << 1) + p[6] - p[2] - (p[5] << 1) - p[8];
                r_g[ch] <= '{gv: sem_pkg::clamp_grad(gv), gh: sem_pkg::clamp_grad(gh)};
            end
            r_tag <= '{row: PosWidthCast(r_r - CW'(1)), col: PosWidthCast(r_c - CW'(1)),
                       last: (r_r == side - CW'(1)) && (r_c == side - CW'(1))};
        end
        if (sq_done[0]) begin
            r_out <= '{out_row: r_tag.row, out_col: r_tag.col, mag_red: sq_root[0],
                       mag_green: sq_root[1], mag_blue: sq_root[2], frame_last: r_tag.last};
        end
    end

    function automatic logic [sem_pkg::PosWidth-1:0] PosWidthCast(input logic [CW-1:0] v);
        return v[sem_pkg::PosWidth-1:0];
    endfunction

    for (genvar ch = 0; ch < 3; ch++) begin : g_root
        assign sq_val[ch] = ({9'd0, r_g[ch].gv} * {9'd0, r_g[ch].gv})
                          + ({9'd0, r_g[ch].gh} * {9'd0, r_g[ch].gh});
        sem_isqrt u_sq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (sq_start),
            .i_value (sq_val[ch]),
            .o_done  (sq_done[ch]),
            .o_root  (sq_root[ch])
        );
    end

    assign o_mag_valid = r_ovalid;
    assign o_mag = r_out;

endmodule
`default_nettype wire

@@ sv/sem_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sem_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_pix_valid,
    input wire logic              o_pix_stall,
    input wire logic              o_mag_valid,
    input wire logic              i_mag_stall,
    input wire sem_pkg::t_mag_out o_mag
);

    ast_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mag_valid && i_mag_stall |=> o_mag_valid && $stable(o_mag))
        else $error("stalled result changed");

    ast_pix_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !o_pix_stall |=> o_pix_stall)
        else $error("pixels accepted back to back");

    ast_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mag_valid |-> o_mag.mag_red <= 9'd360 && o_mag.mag_green <= 9'd360
                        && o_mag.mag_blue <= 9'd360)
        else $error("magnitude out of range");

    ast_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_mag_valid)
        else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude_rgb_core sem_checker u_sem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix_valid),
    .o_pix_stall (o_pix_stall),
    .o_mag_valid (o_mag_valid),
    .i_mag_stall (i_mag_stall),
    .o_mag       (o_mag)
);
`default_nettype wire

@@ bench/tb_sobel_edge_magnitude_rgb_core.sv @@
`timescale 1ns / 1ps
module tb_sobel_edge_magnitude_rgb_core;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [sem_pkg::SideWidth-1:0] i_cfg_data;
    logic                          i_pix_valid;
    logic                          o_pix_stall;
    sem_pkg::t_pix_in              i_pix;
    logic                          o_mag_valid;
    logic                          i_mag_stall;
    sem_pkg::t_mag_out             o_mag;

    sobel_edge_magnitude_rgb_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_pix       (i_pix),
        .o_mag_valid (o_mag_valid),
        .i_mag_stall (i_mag_stall),
        .o_mag       (o_mag)
    );

    localparam int WatchLimit  = 5000;
    localparam int DrainPad    = 30;
    localparam int RandomItems = 920;

    // Shadow of the block used to predict magnitudes.
    logic [23:0]                   shadow_above  [sem_pkg::MaxSide];
    logic [23:0]                   shadow_above2 [sem_pkg::MaxSide];
    logic [23:0]                   shadow_win    [9];
    int unsigned                   shadow_row;
    int unsigned                   shadow_col;
    logic [sem_pkg::SideWidth-1:0] shadow_side;

    sem_pkg::t_mag_out mag_expected [$];
    int       mismatches;
    int       idle_cycles;
    bit       calm;
    int       stall_left;
    int       random_items;

    typedef struct {
        sem_pkg::t_pix_in  pix;
        bit                typed;
        sem_pkg::t_mag_out mag;
    } t_row;

    t_row directed [$];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int unsigned floor_root(int unsigned n);
        int unsigned res;
        int unsigned trial;
        res = 0;
        for (int b = 8; b >= 0; b--) begin
            trial = res | (1 << b);
            if (trial * trial <= n) begin
                res = trial;
            end
        end
        return res;
    endfunction

    function automatic int clip_byte(int v);
        if (v < 0) begin
            return 0;
        end
        if (v > 255) begin
            return 255;
        end
        return v;
    endfunction

    function automatic logic [sem_pkg::MagWidth-1:0] channel_mag(int shift);
        int p [9];
        int gv;
        int gh;
        for (int k = 0; k < 9; k++) begin
            p[k] = (shadow_win[k] >> shift) & 8'hFF;
        end
        gv = clip_byte(p[0] + 2 * p[1] + p[2] - p[6] - 2 * p[7] - p[8]);
        gh = clip_byte(p[0] + 2 * p[3] + p[6] - p[2] - 2 * p[5] - p[8]);
        return sem_pkg::MagWidth'(floor_root(gv * gv + gh * gh));
    endfunction

    function automatic bit sobel_predict(input sem_pkg::t_pix_in p,
                                         output sem_pkg::t_mag_out m);
        int unsigned side;
        int unsigned r;
        int unsigned c;
        logic [23:0] px;
        logic [23:0] up1;
        logic [23:0] up2;
        bit          emit;
        side = 32'(shadow_side);
        if (side < 3) begin
            side = 3;
        end
        if (side > sem_pkg::MaxSide) begin
            side = sem_pkg::MaxSide;
        end
        px = {p.pix_red, p.pix_green, p.pix_blue};
        if (p.frame_start) begin
            shadow_row = 0;
            shadow_col = 0;
        end
        r = shadow_row;
        c = shadow_col;
        up1 = '0;
        up2 = '0;
        if (c < sem_pkg::MaxSide) begin
            up1 = shadow_above[c];
            up2 = shadow_above2[c];
            shadow_above2[c] = up1;
            shadow_above[c] = px;
        end
        for (int k = 0; k < 3; k++) begin
            shadow_win[k * 3] = shadow_win[k * 3 + 1];
            shadow_win[k * 3 + 1] = shadow_win[k * 3 + 2];
        end
        shadow_win[2] = up2;
        shadow_win[5] = up1;
        shadow_win[8] = px;
        m = '0;
        emit = (r >= 2) && (c >= 2) && (r < side) && (c < side);
        if (emit) begin
            m.out_row = sem_pkg::PosWidth'(r - 1);
            m.out_col = sem_pkg::PosWidth'(c - 1);
            m.mag_red = channel_mag(16);
            m.mag_green = channel_mag(8);
            m.mag_blue = channel_mag(0);
            m.frame_last = (r == side - 1) && (c == side - 1);
        end
        if (c + 1 >= side) begin
            shadow_col = 0;
            shadow_row = (r + 1 >= side) ? 0 : r + 1;
        end else begin
            shadow_col = c + 1;
        end
        return emit;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55) begin
            return 0;
        end
        if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pix(input sem_pkg::t_pix_in p, input bit typed,
                            input sem_pkg::t_mag_out typed_mag);
        int                g;
        sem_pkg::t_mag_out m;
        g = gap_len();
        if (g > 0) begin
            i_pix_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_pix_valid <= 1'b1;
        i_pix <= p;
        do begin
            @(posedge i_clk);
        end while (o_pix_stall);
        if (sobel_predict(p, m)) begin
            mag_expected.push_back(typed ? typed_mag : m);
        end
    endtask

    task automatic drain();
        i_pix_valid <= 1'b0;
        while (mag_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainPad) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [sem_pkg::SideWidth-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_side = v;
    endtask

    function automatic sem_pkg::t_pix_in rand_pix(input bit start);
        sem_pkg::t_pix_in p;
        int               mode;
        mode = $urandom_range(0, 3);
        p.frame_start = start;
        if (mode == 0) begin
            p.pix_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.pix_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.pix_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            p.pix_red = 8'($urandom_range(0, 255));
            p.pix_green = 8'($urandom_range(0, 255));
            p.pix_blue = 8'($urandom_range(0, 255));
        end
        return p;
    endfunction

    task automatic send_image(input bit use_start, input int count);
        sem_pkg::t_pix_in  p;
        sem_pkg::t_mag_out none;
        bit                start;
        none = '0;
        for (int i = 0; i < count; i++) begin
            start = (i == 0) ? use_start : ($urandom_range(0, 199) == 0);
            p = rand_pix(start);
            send_pix(p, 1'b0, none);
        end
    endtask

    function automatic sem_pkg::t_pix_in flat_pix(input bit start, input logic [7:0] v);
        sem_pkg::t_pix_in p;
        p.frame_start = start;
        p.pix_red = v;
        p.pix_green = v;
        p.pix_blue = v;
        return p;
    endfunction

    task automatic build_directed();
        t_row row;
        // Three 3x3 images: flat white, bright top row, bright top row and
        // left column. Only the last pixel of each yields a result.
        for (int img = 0; img < 3; img++) begin
            for (int k = 0; k < 9; k++) begin
                row.typed = 1'b0;
                row.mag = '0;
                if (img == 0) begin
                    row.pix = flat_pix(k == 0, 8'hFF);
                end else if (img == 1) begin
                    row.pix = flat_pix(k == 0, (k < 3) ? 8'hFF : 8'h00);
                end else begin
                    row.pix = flat_pix(k == 0, (k < 3 || k % 3 == 0) ? 8'hFF : 8'h00);
                end
                if (k == 8) begin
                    row.typed = 1'b1;
                    row.mag.out_row = 10'd1;
                    row.mag.out_col = 10'd1;
                    row.mag.frame_last = 1'b1;
                    row.mag.mag_red = (img == 0) ? 9'd0 : (img == 1) ? 9'd255 : 9'd360;
                    row.mag.mag_green = row.mag.mag_red;
                    row.mag.mag_blue = row.mag.mag_red;
                end
                directed.push_back(row);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_mag_valid && !i_mag_stall) begin
            if (mag_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transfer: %p", o_mag);
                end
            end else begin
                sem_pkg::t_mag_out e;
                e = mag_expected.pop_front();
                if (o_mag.out_row !== e.out_row || o_mag.out_col !== e.out_col
                        || o_mag.mag_red !== e.mag_red || o_mag.mag_green !== e.mag_green
                        || o_mag.mag_blue !== e.mag_blue
                        || o_mag.frame_last !== e.frame_last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("expected %p", e);
                        $display("actual   %p", o_mag);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int pick;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_mag_stall <= 1'b1;
        end else if (calm) begin
            i_mag_stall <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                i_mag_stall <= 1'b0;
            end else if (pick < 95) begin
                i_mag_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_mag_stall <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_pix_valid && !o_pix_stall) || (o_mag_valid && !i_mag_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("sobel_edge_magnitude_rgb_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int unsigned side;
        int          images;
        int          count;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_pix_valid = 1'b0;
        i_pix = '0;
        i_mag_stall = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        calm = 1'b0;
        stall_left = 0;
        random_items = 0;
        shadow_side = sem_pkg::SideReset;
        shadow_row = 0;
        shadow_col = 0;
        for (int k = 0; k < 9; k++) begin
            shadow_win[k] = '0;
        end
        for (int k = 0; k < sem_pkg::MaxSide; k++) begin
            shadow_above[k] = '0;
            shadow_above2[k] = '0;
        end
        build_directed();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_side(0);
        foreach (directed[i]) begin
            send_pix(directed[i].pix, directed[i].typed, directed[i].mag);
        end

        while (random_items < RandomItems) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: side = $urandom_range(0, 2);
                1: side = $urandom_range(20, 40);
                default: side = $urandom_range(3, 12);
            endcase
            write_side(sem_pkg::SideWidth'(side));
            if (side < 3) begin
                side = 3;
            end
            images = $urandom_range(1, 3);
            for (int n = 0; n < images; n++) begin
                count = side * side;
                if (count > RandomItems - random_items) begin
                    count = RandomItems - random_items;
                end
                send_image((n == 0) || $urandom_range(0, 1), count);
                random_items += count;
            end
        end
        calm = 1'b0;

        // Shrink the side in the middle of an image and carry on without a
        // new frame start.
        write_side(8);
        send_image(1'b1, 30);
        write_side(5);
        send_image(1'b0, 6);

        // Oversized side acts as the largest one; the first row stays short
        // of the wrap.
        write_side(11'h7FF);
        send_image(1'b1, 40);

        write_side(3);
        send_image(1'b1, 9);
        drain();

        if (mismatches == 0) begin
            $display("sobel_edge_magnitude_rgb_core: match");
        end else begin
            $display("sobel_edge_magnitude_rgb_core: mismatch");
        end
        $finish;
    end
endmodule

@@ sim.f @@
sv/sem_pkg.sv
sv/sem_line_mem.sv
sv/sem_isqrt.sv
sv/sobel_edge_magnitude_rgb_core.sv
sv/sem_checker.sv
bench/tb_sobel_edge_magnitude_rgb_core.sv
